/* design/lsbsd_pkg.sv */
// Shared types and constants for the LSB stego stream decoder.
`timescale 1ns / 1ps

package lsbsd_pkg;

  // Widths fixed by the stream format
  localparam int unsigned ImgW   = 8;
  localparam int unsigned MagicW = 64;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CntW   = 5;
  localparam int unsigned ItemW  = 31;
  localparam int unsigned MagMaxChars = 8;

  // Configuration register indexes
  localparam logic [1:0] CfgHeaderBytes = 2'd0;
  localparam logic [1:0] CfgMagicLength = 2'd1;
  localparam logic [1:0] CfgMagicWord   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0]        HeaderBytesRst = 8'd54;
  localparam logic [3:0]        MagicLengthRst = 4'd2;
  localparam logic [MagicW-1:0] MagicWordRst   = 64'd10787;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_MAGIC,
    PH_EXTLEN,
    PH_EXT,
    PH_DATALEN,
    PH_DATA,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_EXT    = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_BUSY   = 2'd0,
    STAT_OK     = 2'd1,
    STAT_MAGIC  = 2'd2,
    STAT_EXTLEN = 2'd3
  } status_e;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    status_e    status;
    logic       last;
  } res_t;

  // Configuration seen by the parser
  typedef struct packed {
    logic [7:0]        header_bytes;
    logic [3:0]        magic_length;
    logic [MagicW-1:0] magic_word;
  } cfg_t;

endpackage

/* design/lsbsd_in_reg.sv */
// Input register stage holding one accepted image byte request.
`timescale 1ns / 1ps

module lsbsd_in_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [lsbsd_pkg::ImgW-1:0] byte_i,
  input  logic                     frame_start_i,
  output logic                     valid_o,
  input  logic                     advance_i,
  output logic                     bit_o,
  output logic                     frame_start_o
);
  import lsbsd_pkg::*;

  logic valid_q, valid_d;
  logic bit_q, fs_q;

  // Take a new request when empty or when the held one moves on
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Only bit 0 of the image byte carries payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bit_q <= byte_i[0];
      fs_q  <= frame_start_i;
    end
  end

  assign valid_o       = valid_q;
  assign bit_o         = bit_q;
  assign frame_start_o = fs_q;

endmodule

/* design/lsbsd_parser.sv */
// Parse state and single-step decode of one payload bit.
`timescale 1ns / 1ps

module lsbsd_parser #(
  parameter int unsigned EXTENSION_CAPACITY = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              bit_i,
  input  logic              frame_start_i,
  input  lsbsd_pkg::cfg_t   cfg_i,
  output logic              res_valid_o,
  output lsbsd_pkg::res_t   res_o
);
  import lsbsd_pkg::*;

  localparam int unsigned ElW = (EXTENSION_CAPACITY > 1) ? $clog2(EXTENSION_CAPACITY) : 1;

  phase_e            phase_q, phase_d;
  logic [7:0]        hc_q, hc_d;
  logic [CntW-1:0]   bc_q, bc_d;
  logic [WordW-1:0]  acc_q, acc_d;
  logic [ItemW-1:0]  ic_q, ic_d;
  logic [ElW-1:0]    el_q, el_d;
  logic [ItemW-1:0]  dl_q, dl_d;

  logic              run;
  logic              wide;
  logic              full;
  logic [CntW:0]     cnt1;
  logic [WordW-1:0]  acc_sh;
  logic [3:0]        mcnt;
  logic [7:0]        want;
  logic [ItemW-1:0]  ic_inc;

  // Effective magic character count, capped at eight
  assign mcnt = (cfg_i.magic_length > 4'(MagMaxChars)) ? 4'(MagMaxChars) : cfg_i.magic_length;

  always_comb begin
    phase_d = phase_q;
    hc_d    = hc_q;
    bc_d    = bc_q;
    acc_d   = acc_q;
    ic_d    = ic_q;
    el_d    = el_q;
    dl_d    = dl_q;
    res_valid_o = 1'b0;
    res_o   = '{data: 8'd0, kind: KIND_STATUS, status: STAT_BUSY, last: 1'b0};
    run     = 1'b1;
    full    = 1'b0;
    acc_sh  = '0;
    cnt1    = '0;
    want    = '0;
    ic_inc  = '0;

    // Restart the parse on a frame start
    if (frame_start_i) begin
      phase_d = PH_HEADER;
      hc_d    = '0;
      bc_d    = '0;
      acc_d   = '0;
      ic_d    = '0;
      el_d    = '0;
      dl_d    = '0;
    end

    // Skip header bytes, then fall into the first payload phase
    if (phase_d == PH_HEADER) begin
      if (hc_d < cfg_i.header_bytes) begin
        hc_d = hc_d + 8'd1;
        run  = 1'b0;
      end else begin
        ic_d    = '0;
        phase_d = (mcnt == 4'd0) ? PH_EXTLEN : PH_MAGIC;
      end
    end

    wide = (phase_d == PH_EXTLEN) || (phase_d == PH_DATALEN);

    // Shift the payload bit in, MSB first
    if (run && (phase_d != PH_DONE) && (phase_d != PH_HEADER)) begin
      acc_sh = {acc_d[WordW-2:0], bit_i};
      cnt1   = {1'b0, bc_d} + (CntW+1)'(1);
      full   = wide ? (cnt1 >= (CntW+1)'(WordW)) : (cnt1 >= (CntW+1)'(8));
      if (full) begin
        acc_d = '0;
        bc_d  = '0;
      end else begin
        acc_d = acc_sh;
        bc_d  = cnt1[CntW-1:0];
      end
    end

    ic_inc = ic_d + ItemW'(1);
    want   = cfg_i.magic_word[{ic_d[2:0], 3'b000} +: 8];

    if (full) begin
      unique case (phase_d)
        PH_MAGIC: begin
          if (acc_sh[7:0] != want) begin
            phase_d     = PH_DONE;
            res_valid_o = 1'b1;
            res_o       = '{data: 8'd0, kind: KIND_STATUS, status: STAT_MAGIC, last: 1'b1};
          end else begin
            ic_d = ic_inc;
            if (ic_inc >= ItemW'(mcnt)) begin
              ic_d    = '0;
              phase_d = PH_EXTLEN;
            end
          end
        end
        PH_EXTLEN: begin
          if (acc_sh[WordW-1] || (acc_sh >= WordW'(EXTENSION_CAPACITY))) begin
            phase_d     = PH_DONE;
            res_valid_o = 1'b1;
            res_o       = '{data: 8'd0, kind: KIND_STATUS, status: STAT_EXTLEN, last: 1'b1};
          end else begin
            el_d    = acc_sh[ElW-1:0];
            ic_d    = '0;
            phase_d = (acc_sh == '0) ? PH_DATALEN : PH_EXT;
          end
        end
        PH_EXT: begin
          ic_d = ic_inc;
          if (ic_inc >= ItemW'(el_d)) begin
            ic_d    = '0;
            phase_d = PH_DATALEN;
          end
          res_valid_o = 1'b1;
          res_o       = '{data: acc_sh[7:0], kind: KIND_EXT, status: STAT_BUSY, last: 1'b0};
        end
        PH_DATALEN: begin
          dl_d = acc_sh[ItemW-1:0];
          ic_d = '0;
          if (acc_sh[WordW-1] || (acc_sh == '0)) begin
            phase_d     = PH_DONE;
            res_valid_o = 1'b1;
            res_o       = '{data: 8'd0, kind: KIND_STATUS, status: STAT_OK, last: 1'b1};
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          ic_d        = ic_inc;
          res_valid_o = 1'b1;
          if (ic_inc >= dl_d) begin
            phase_d = PH_DONE;
            res_o   = '{data: acc_sh[7:0], kind: KIND_DATA, status: STAT_OK, last: 1'b1};
          end else begin
            res_o   = '{data: acc_sh[7:0], kind: KIND_DATA, status: STAT_BUSY, last: 1'b0};
          end
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end

    // Hold everything unless a request steps the parser
    if (!step_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hc_q    <= '0;
      bc_q    <= '0;
      acc_q   <= '0;
      ic_q    <= '0;
      el_q    <= '0;
      dl_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      bc_q    <= bc_d;
      acc_q   <= acc_d;
      ic_q    <= ic_d;
      el_q    <= el_d;
      dl_q    <= dl_d;
    end
  end

endmodule

/* design/lsbsd_out_reg.sv */
// Result register driving the output stream.
`timescale 1ns / 1ps

module lsbsd_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  lsbsd_pkg::res_t res_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            ready_i,
  output lsbsd_pkg::res_t res_o
);
  import lsbsd_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Free when empty or when the held result is taken this cycle
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* design/lsb_stego_stream_decoder_unit.sv */
// A byte's result, if any, loads the result register after the input register.
// Throughput: one byte per cycle unless the output stalls; at most one result per byte.
// The input register, one step of parse logic and the result register set that rate.
// Reset clears the parse to the header skip phase and loads the register defaults.
// Output stalls back up through the result register to the input side.
`timescale 1ns / 1ps

module lsb_stego_stream_decoder_unit #(
  parameter int unsigned EXTENSION_CAPACITY = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] image_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] decoded_byte
  output logic [3:0]  m_axis_tuser_o,   // [1:0] result_kind, [3:2] status_code
  output logic        m_axis_tlast_o,   // last_of_frame
  // Configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  import lsbsd_pkg::*;

  cfg_t cfg_q;
  logic in_valid, in_bit, in_fs;
  logic out_ready, step;
  logic res_valid;
  res_t res, res_out;

  // Write configuration registers; other indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_bytes <= HeaderBytesRst;
      cfg_q.magic_length <= MagicLengthRst;
      cfg_q.magic_word   <= MagicWordRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHeaderBytes: cfg_q.header_bytes <= cfg_data_i[7:0];
        CfgMagicLength: cfg_q.magic_length <= cfg_data_i[3:0];
        CfgMagicWord:   cfg_q.magic_word   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the held request when the result register has room
  assign step = in_valid && out_ready;

  lsbsd_in_reg u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid_i),
    .ready_o       (s_axis_tready_o),
    .byte_i        (s_axis_tdata_i),
    .frame_start_i (s_axis_tuser_i),
    .valid_o       (in_valid),
    .advance_i     (out_ready),
    .bit_o         (in_bit),
    .frame_start_o (in_fs)
  );

  lsbsd_parser #(
    .EXTENSION_CAPACITY (EXTENSION_CAPACITY)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .bit_i         (in_bit),
    .frame_start_i (in_fs),
    .cfg_i         (cfg_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  lsbsd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res_out)
  );

  assign m_axis_tdata_o = res_out.data;
  assign m_axis_tuser_o = {res_out.status, res_out.kind};
  assign m_axis_tlast_o = res_out.last;

endmodule

/* dv/lsbsd_checker.sv */
// Checker for the LSB stego stream decoder: predicts results and compares them.
`timescale 1ns / 1ps

module lsbsd_checker #(
  parameter int unsigned ExtCap = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] image_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // [7:0] decoded_byte
  input  logic [3:0]  m_axis_tuser_i,   // [1:0] result_kind, [3:2] status_code
  input  logic        m_axis_tlast_i,   // last_of_frame
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  import lsbsd_pkg::*;

  // Shadow copy of the configuration and the parse state
  cfg_t        cfg;
  phase_e      phase;
  logic [7:0]  hdr_cnt;
  logic [5:0]  bit_cnt;
  logic [31:0] acc;
  logic [31:0] item_cnt;
  logic [31:0] ext_len;
  logic [31:0] data_len;

  res_t        decoded_q[$];
  res_t        want;
  res_t        fresh;
  int          n_fail;

  function automatic void clear_parse();
    phase    = PH_HEADER;
    hdr_cnt  = '0;
    bit_cnt  = '0;
    acc      = '0;
    item_cnt = '0;
    ext_len  = '0;
    data_len = '0;
  endfunction

  function automatic res_t make_res(input logic [7:0] d, input kind_e k, input status_e s,
                                    input logic l);
    res_t r;
    r.data   = d;
    r.kind   = k;
    r.status = s;
    r.last   = l;
    return r;
  endfunction

  // Shift one payload bit in MSB first; true once a full character or word is in
  function automatic logic shift_payload_bit(input logic b, input int need,
                                             output logic [31:0] v);
    acc     = {acc[30:0], b};
    bit_cnt = bit_cnt + 6'd1;
    v       = '0;
    if (bit_cnt >= need) begin
      if (need >= 32) v = acc;
      else v = {24'd0, acc[7:0]};
      acc     = '0;
      bit_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the parse by one image byte; true when the byte yields a result
  function automatic logic decode_image_byte(input logic [7:0] b, input logic sof,
                                             output res_t r);
    logic [31:0] v;
    logic [3:0]  n_mag;
    logic [63:0] mw;
    logic [7:0]  ch_want;

    r = make_res(8'd0, KIND_STATUS, STAT_BUSY, 1'b0);
    if (sof) clear_parse();
    if (cfg.magic_length > 4'd8) n_mag = 4'd8;
    else n_mag = cfg.magic_length;

    if (phase == PH_HEADER) begin
      if (hdr_cnt < cfg.header_bytes) begin
        hdr_cnt = hdr_cnt + 8'd1;
        return 1'b0;
      end
      item_cnt = '0;
      if (n_mag == 4'd0) phase = PH_EXTLEN;
      else phase = PH_MAGIC;
    end

    case (phase)
      PH_MAGIC: begin
        if (!shift_payload_bit(b[0], 8, v)) return 1'b0;
        mw      = cfg.magic_word >> (8 * item_cnt[2:0]);
        ch_want = mw[7:0];
        if (v[7:0] != ch_want) begin
          phase = PH_DONE;
          r = make_res(8'd0, KIND_STATUS, STAT_MAGIC, 1'b1);
          return 1'b1;
        end
        item_cnt = item_cnt + 1;
        if (item_cnt >= n_mag) begin
          item_cnt = '0;
          phase    = PH_EXTLEN;
        end
        return 1'b0;
      end
      PH_EXTLEN: begin
        if (!shift_payload_bit(b[0], 32, v)) return 1'b0;
        if (v[31] || v >= ExtCap) begin
          phase = PH_DONE;
          r = make_res(8'd0, KIND_STATUS, STAT_EXTLEN, 1'b1);
          return 1'b1;
        end
        ext_len  = v;
        item_cnt = '0;
        if (v == 0) phase = PH_DATALEN;
        else phase = PH_EXT;
        return 1'b0;
      end
      PH_EXT: begin
        if (!shift_payload_bit(b[0], 8, v)) return 1'b0;
        item_cnt = item_cnt + 1;
        if (item_cnt >= ext_len) begin
          item_cnt = '0;
          phase    = PH_DATALEN;
        end
        r = make_res(v[7:0], KIND_EXT, STAT_BUSY, 1'b0);
        return 1'b1;
      end
      PH_DATALEN: begin
        if (!shift_payload_bit(b[0], 32, v)) return 1'b0;
        data_len = v;
        item_cnt = '0;
        if (v[31] || v == 0) begin
          phase = PH_DONE;
          r = make_res(8'd0, KIND_STATUS, STAT_OK, 1'b1);
          return 1'b1;
        end
        phase = PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        if (!shift_payload_bit(b[0], 8, v)) return 1'b0;
        item_cnt = item_cnt + 1;
        if (item_cnt >= data_len) begin
          phase = PH_DONE;
          r = make_res(v[7:0], KIND_DATA, STAT_OK, 1'b1);
          return 1'b1;
        end
        r = make_res(v[7:0], KIND_DATA, STAT_BUSY, 1'b0);
        return 1'b1;
      end
      default: begin
        phase = PH_DONE;
        return 1'b0;
      end
    endcase
  endfunction

  // Check results first, then predict from the accepted request, then take register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.header_bytes = HeaderBytesRst;
      cfg.magic_length = MagicLengthRst;
      cfg.magic_word   = MagicWordRst;
      clear_parse();
      decoded_q.delete();
      n_fail = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: decoded_byte %0h result_kind %0d status_code %0d",
                 m_axis_tdata_i, m_axis_tuser_i[1:0], m_axis_tuser_i[3:2]);
          n_fail++;
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata_i !== want.data) begin
            $error("decoded_byte: expected %0h, got %0h", want.data, m_axis_tdata_i);
            n_fail++;
          end
          if (m_axis_tuser_i[1:0] !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, m_axis_tuser_i[1:0]);
            n_fail++;
          end
          if (m_axis_tuser_i[3:2] !== want.status) begin
            $error("status_code: expected %0d, got %0d", want.status, m_axis_tuser_i[3:2]);
            n_fail++;
          end
          if (m_axis_tlast_i !== want.last) begin
            $error("last_of_frame: expected %0d, got %0d", want.last, m_axis_tlast_i);
            n_fail++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (decode_image_byte(s_axis_tdata_i, s_axis_tuser_i, fresh))
          decoded_q.push_back(fresh);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHeaderBytes: cfg.header_bytes = cfg_data_i[7:0];
          CfgMagicLength: cfg.magic_length = cfg_data_i[3:0];
          CfgMagicWord:   cfg.magic_word   = cfg_data_i;
          default: ;
        endcase
      end
      fail_cnt_o <= n_fail;
      pending_o  <= decoded_q.size();
    end
  end

endmodule

/* dv/tb.sv */
// Testbench top for the LSB stego stream decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;

  import lsbsd_pkg::*;

  localparam int unsigned ExtCap   = 8;
  localparam int          MaxCycle = 600000;
  localparam int          NumItems = 1650;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CfgHeaderBytes;
  logic [63:0] cfg_data = 64'd0;

  int          fails;
  int          pending;
  int          cycles = 0;
  int          n_items = 0;
  bit          calm = 1'b0;

  // Configuration as last written, used to build well-formed frames
  logic [7:0]  cur_hb = HeaderBytesRst;
  logic [3:0]  cur_ml = MagicLengthRst;
  logic [63:0] cur_mw = MagicWordRst;
  logic        pay_q[$];

  always #2 clk = ~clk;

  lsb_stego_stream_decoder_unit #(
    .EXTENSION_CAPACITY(ExtCap)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  lsbsd_checker #(
    .ExtCap(ExtCap)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .fail_cnt_o      (fails),
    .pending_o       (pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycle) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one image byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int w;
    w = calm ? 0 : $urandom_range(0, 15);
    if (w > 0) begin
      s_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] hb, input logic [3:0] ml, input logic [63:0] mw);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgHeaderBytes;
    cfg_data <= {56'd0, hb};
    @(posedge clk);
    cfg_idx  <= CfgMagicLength;
    cfg_data <= {60'd0, ml};
    @(posedge clk);
    cfg_idx  <= CfgMagicWord;
    cfg_data <= mw;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_hb = hb;
    cur_ml = ml;
    cur_mw = mw;
  endtask

  task automatic push_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) pay_q.push_back(v[i]);
  endtask

  // Build one image: header, magic, extension length and text, data length and data.
  // A nonzero cut truncates the frame; tail bytes follow with random payload bits.
  task automatic send_frame(input bit bad_magic, input logic [31:0] ext_w,
                            input logic [31:0] data_w, input int cut, input int tail);
    int         n_mag;
    int         bad_at;
    int         n_dat;
    int         hb;
    int         body;
    logic [7:0] ch;
    logic [7:0] b;
    pay_q.delete();
    n_mag  = (cur_ml > 4'd8) ? 8 : cur_ml;
    bad_at = (bad_magic && n_mag > 0) ? $urandom_range(0, n_mag - 1) : -1;
    for (int i = 0; i < n_mag; i++) begin
      ch = cur_mw[8*i +: 8];
      if (i == bad_at) ch = ch ^ (8'd1 << $urandom_range(0, 7));
      push_bits({24'd0, ch}, 8);
    end
    push_bits(ext_w, 32);
    if (!ext_w[31] && ext_w < ExtCap) begin
      for (int i = 0; i < ext_w; i++) push_bits($urandom, 8);
      push_bits(data_w, 32);
      n_dat = data_w[31] ? 0 : ((data_w > 16) ? 16 : data_w);
      for (int i = 0; i < n_dat; i++) push_bits($urandom, 8);
    end
    hb   = cur_hb;
    body = hb + pay_q.size();
    if (cut > 0 && cut < body) body = cut;
    for (int k = 0; k < body + tail; k++) begin
      b = $urandom;
      if (k < body && k >= hb && (k - hb) < pay_q.size()) b[0] = pay_q[k - hb];
      send_byte(b, k == 0);
      if (k < body) n_items++;
    end
  endtask

  // Result side: random stalls, quiet stretches, and one long hold-off
  initial begin
    int w;
    int got;
    bit held;
    bit rx_calm;
    bit last_seen;
    got = 0;
    held = 1'b0;
    rx_calm = 1'b0;
    last_seen = 1'b1;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (got % 16 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      w = rx_calm ? 0 : $urandom_range(0, 15);
      if (!held && got >= 30 && !last_seen) begin
        w = 600;
        held = 1'b1;
      end
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got++;
      last_seen = m_tlast;
    end
  end

  // Stimulus
  initial begin
    int          sel;
    int          r;
    int          frames;
    logic [7:0]  hb;
    logic [3:0]  ml;
    logic [31:0] ext_w;
    logic [31:0] data_w;
    int          cut;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults after reset
    send_frame(1'b0, 32'd3, 32'd4, 0, 2);
    // Stop inside the data bytes, rewrite the registers, then keep streaming
    send_frame(1'b0, 32'd2, 32'd6, 170, 0);
    drain();
    write_regs(8'd0, 4'd0, 64'd0);
    for (int i = 0; i < 30; i++) send_byte($urandom, 1'b0);
    // Zero header and zero magic; no data, by zero and by a negative length
    send_frame(1'b0, 32'd0, 32'd0, 0, 3);
    send_frame(1'b0, 32'd0, 32'hFFFF_FFFF, 0, 0);
    drain();
    // Full magic, largest extension, a single data byte, then a magic mismatch
    write_regs(8'd1, 4'd8, {$urandom, $urandom});
    send_frame(1'b0, ExtCap - 1, 32'd1, 0, 2);
    send_frame(1'b1, 32'd1, 32'd1, 0, 2);
    drain();
    // Longest header, over-long magic, extension length at capacity
    write_regs(8'd255, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(1'b0, ExtCap, 32'd1, 0, 0);
    drain();
    // Negative and huge extension lengths, negative data length
    write_regs(8'd3, 4'd1, {$urandom, $urandom});
    send_frame(1'b0, 32'h8000_0000, 32'd1, 0, 0);
    send_frame(1'b0, 32'h7FFF_FFFF, 32'd1, 0, 1);
    send_frame(1'b0, 32'd1, 32'h8000_0000, 0, 1);

    // Random frames, mostly well formed
    frames  = 0;
    while (n_items < NumItems) begin
      if (frames % 3 == 0) begin
        drain();
        r  = $urandom_range(0, 19);
        if (r < 12) hb = $urandom_range(0, 8);
        else if (r < 19) hb = $urandom_range(9, 60);
        else hb = 8'd255;
        ml = $urandom_range(0, 15);
        write_regs(hb, ml, {$urandom, $urandom});
      end
      calm   = ($urandom_range(0, 3) == 0);
      sel    = $urandom_range(0, 9);
      ext_w  = $urandom_range(0, ExtCap - 1);
      data_w = $urandom_range(1, 12);
      cut    = 0;
      if (sel == 0) data_w = $urandom_range(0, 1) ? 32'd0 : ($urandom | 32'h8000_0000);
      if (sel == 2) ext_w = $urandom_range(0, 1) ? ($urandom | 32'h8000_0000)
                                                 : $urandom_range(ExtCap, 1000);
      if (sel == 3) cut = $urandom_range(1, 150);
      send_frame(sel == 1, ext_w, data_w, cut, $urandom_range(0, 4));
      frames++;
    end

    drain();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
